[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lbps_pkg.sv]
`timescale 1ns / 1ps

package lbps_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned WaitW  = 8;
  localparam int unsigned PatW   = 5;
  localparam int unsigned RemSteps = CntW / 2;
  localparam int unsigned RemCntW  = $clog2(RemSteps);

  localparam logic [WaitW-1:0] StartDelayReset = 8'd20;
  localparam logic [CntW-1:0]  PatEndless      = 16'h00FF;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_LIGHT = 2'd1,
    REQ_BUZZ  = 2'd2,
    REQ_FORCE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LSTART,
    ST_LWAIT,
    ST_TSTART,
    ST_TWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [CntW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [CntW-1:0] rem;
  } rem_rsp_t;

  typedef struct packed {
    logic            hit;
    logic [CntW-1:0] dur;
    logic [CntW-1:0] period;
    logic [CntW-1:0] span;
    logic [3:0]      colour;
  } row_t;

  function automatic row_t mk_row(input logic [CntW-1:0] d, input logic [CntW-1:0] p,
                                  input logic [CntW-1:0] s, input logic [3:0] c);
    row_t r;
    r.hit    = 1'b1;
    r.dur    = d;
    r.period = p;
    r.span   = s;
    r.colour = c;
    return r;
  endfunction

  // colour: bit 3 red, bit 2 green, bit 0 blue
  function automatic row_t lamp_row(input logic [PatW-1:0] p);
    row_t r;
    r = '0;
    case (p)
      5'd1, 5'd2, 5'd3: r = mk_row(16'd20, 16'd40, 16'd20, 4'h1);
      5'd4:  r = mk_row(16'd80, 16'd40, 16'd20, 4'h8);
      5'd5:  r = mk_row(16'd20, 16'd40, 16'd20, 4'h4);
      5'd6:  r = mk_row(16'h00FF, 16'd100, 16'd50, 4'h4);
      5'd7:  r = mk_row(16'h00FF, 16'h00FF, 16'h00FF, 4'h4);
      5'd8:  r = mk_row(16'h00FF, 16'h00FF, 16'h00FF, 4'h8);
      5'd9:  r = mk_row(16'h00FF, 16'd120, 16'd60, 4'h1);
      5'd10: r = mk_row(16'h00FF, 16'd300, 16'd200, 4'hD);
      5'd11: r = mk_row(16'h00FF, 16'h00FF, 16'h00FF, 4'h5);
      5'd12: r = mk_row(16'd36, 16'd12, 16'd6, 4'h4);
      5'd13: r = mk_row(16'd60, 16'd20, 16'd10, 4'h1);
      5'd14: r = mk_row(16'h00FF, 16'd120, 16'd60, 4'h8);
      5'd15: r = mk_row(16'h00FF, 16'd80, 16'd40, 4'hD);
      5'd16: r = mk_row(16'h00FF, 16'd60, 16'd30, 4'h8);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic row_t buzz_row(input logic [PatW-1:0] p);
    row_t r;
    r = '0;
    case (p)
      5'd1: r = mk_row(16'd20, 16'd40, 16'd20, 4'h0);
      5'd2: r = mk_row(16'd80, 16'd40, 16'd20, 4'h0);
      5'd3: r = mk_row(16'd160, 16'd80, 16'd40, 4'h0);
      5'd4: r = mk_row(16'd500, 16'hFFFF, 16'hFFFF, 4'h0);
      5'd5: r = mk_row(16'd30, 16'd10, 16'd5, 4'h0);
      5'd6: r = mk_row(16'd60, 16'd20, 16'd10, 4'h0);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/lbps_rem.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Restoring remainder, two quotient bits per cycle. A zero divisor gives
// the dividend back unchanged.
module lbps_rem (
  input  logic              clk,
  input  logic              rst,
  input  lbps_pkg::rem_req_t req,
  output lbps_pkg::rem_rsp_t rsp
);

  logic [lbps_pkg::CntW-1:0]    rem;
  logic [lbps_pkg::CntW-1:0]    rem_next;
  logic [lbps_pkg::CntW-1:0]    dvd;
  logic [lbps_pkg::CntW-1:0]    dvs;
  logic [lbps_pkg::RemCntW-1:0] cnt;
  logic                         busy;
  logic                         done;
  logic [lbps_pkg::CntW:0]      s1;
  logic [lbps_pkg::CntW:0]      s2;

  always_comb begin
    s1 = {rem, dvd[lbps_pkg::CntW-1]};
    if (s1 >= {1'b0, dvs}) begin
      s1 = s1 - {1'b0, dvs};
    end
    s2 = {s1[lbps_pkg::CntW-1:0], dvd[lbps_pkg::CntW-2]};
    if (s2 >= {1'b0, dvs}) begin
      s2 = s2 - {1'b0, dvs};
    end
    rem_next = s2[lbps_pkg::CntW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[lbps_pkg::CntW-3:0], 2'b00};
        cnt <= cnt + 1'b1;
        if (cnt == lbps_pkg::RemCntW'(lbps_pkg::RemSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem;

  `ASSERT_NEXT(a_start_busy, req.start, busy, "remainder unit did not start")
  `ASSERT_IMPLIES(a_done_idle, done, !busy && !req.start, "done while unit still busy")

endmodule

[rtl/led_buzzer_pattern_sequencer.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Tick request: from accept to the earliest result handshake, two remainder passes on the
// one shared divider (each: start, eight 2-bit steps, done), then the output step and the
// result register. Light, buzzer and force requests go straight to the output step. One
// request in flight; the next is accepted in the cycle after the result is loaded, even if
// it has not been taken yet.
// rst (synchronous, high): all pattern state cleared, drives off, start_delay 20.
module led_buzzer_pattern_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] pattern
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] red_on [1] green_on [2] blue_on [3] buzzer_on
                                 // [8:4] light_pattern
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned W  = lbps_pkg::CntW;
  localparam int unsigned WW = lbps_pkg::WaitW;
  localparam int unsigned PW = lbps_pkg::PatW;

  lbps_pkg::state_t state;
  lbps_pkg::state_t state_next;
  lbps_pkg::rem_req_t rq;
  lbps_pkg::rem_rsp_t rs;
  lbps_pkg::req_t req;
  lbps_pkg::row_t lrow;
  lbps_pkg::row_t brow;

  logic [WW-1:0] start_delay;
  logic [PW-1:0] held;
  logic [WW-1:0] l_wait;
  logic [W-1:0]  l_elapsed, l_dur, l_period, l_span;
  logic [3:0]    l_colour;
  logic [WW-1:0] t_wait;
  logic [W-1:0]  t_elapsed, t_dur, t_period, t_span;
  logic [3:0]    drive;      // 3 red, 2 green, 1 blue, 0 buzzer
  logic          l_run, t_run;

  logic [PW-1:0] pat;
  logic          accept;
  logic          out_free;
  logic          l_take;
  logic          l_live, l_lit, t_live;

  assign req      = lbps_pkg::req_t'(s_tuser);
  assign pat      = s_tdata[PW-1:0];
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign lrow     = lbps_pkg::lamp_row(pat);
  assign brow     = lbps_pkg::buzz_row(pat);

  // priority: held 7 and up yields to any other number, 1..6 only to a lower one
  always_comb begin
    if (held >= PW'(7)) begin
      l_take = (held != pat);
    end else begin
      l_take = (held == '0) || (pat < held);
    end
  end

  assign l_live = (l_dur != '0) && ((l_dur == lbps_pkg::PatEndless) || (l_elapsed < l_dur));
  assign l_lit  = (l_period == lbps_pkg::PatEndless) || (rs.rem < l_span);
  assign t_live = (t_dur != '0) && (t_elapsed < t_dur);

  always_comb begin
    state_next = state;
    unique case (state)
      lbps_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (req == lbps_pkg::REQ_TICK) ? lbps_pkg::ST_LSTART : lbps_pkg::ST_OUT;
        end
      end
      lbps_pkg::ST_LSTART: state_next = lbps_pkg::ST_LWAIT;
      lbps_pkg::ST_LWAIT:  if (rs.done) state_next = lbps_pkg::ST_TSTART;
      lbps_pkg::ST_TSTART: state_next = lbps_pkg::ST_TWAIT;
      lbps_pkg::ST_TWAIT:  if (rs.done) state_next = lbps_pkg::ST_OUT;
      lbps_pkg::ST_OUT:    if (out_free) state_next = lbps_pkg::ST_IDLE;
      default:             state_next = lbps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    rq.start    = 1'b0;
    rq.dividend = l_elapsed;
    rq.divisor  = l_period;
    unique case (state)
      lbps_pkg::ST_IDLE:   s_tready = 1'b1;
      lbps_pkg::ST_LSTART: rq.start = 1'b1;
      lbps_pkg::ST_TSTART: begin
        rq.start    = 1'b1;
        rq.dividend = t_elapsed;
        rq.divisor  = t_period;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delay <= lbps_pkg::StartDelayReset;
    end else if (cfg_valid && cfg_ready) begin
      start_delay <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      l_wait    <= '0;
      l_elapsed <= '0;
      l_dur     <= '0;
      l_period  <= '0;
      l_span    <= '0;
      l_colour  <= '0;
      t_wait    <= '0;
      t_elapsed <= '0;
      t_dur     <= '0;
      t_period  <= '0;
      t_span    <= '0;
      drive     <= '0;
      l_run     <= 1'b0;
      t_run     <= 1'b0;
    end else begin
      if (accept) begin
        case (req)
          lbps_pkg::REQ_TICK: begin
            l_run <= (l_wait == '0);
            t_run <= (t_wait == '0);
            if (l_wait == '0) l_elapsed <= l_elapsed + 1'b1;
            else              l_wait    <= l_wait - 1'b1;
            if (t_wait == '0) t_elapsed <= t_elapsed + 1'b1;
            else              t_wait    <= t_wait - 1'b1;
          end
          lbps_pkg::REQ_LIGHT: begin
            if (l_take) begin
              l_wait    <= start_delay;
              held      <= pat;
              l_elapsed <= '0;
              if (lrow.hit) begin
                l_dur    <= lrow.dur;
                l_period <= lrow.period;
                l_span   <= lrow.span;
                l_colour <= lrow.colour;
              end
            end
          end
          lbps_pkg::REQ_BUZZ: begin
            t_wait    <= start_delay;
            t_elapsed <= '0;
            if (brow.hit) begin
              t_dur    <= brow.dur;
              t_period <= brow.period;
              t_span   <= brow.span;
            end
          end
          default: begin
            l_wait    <= start_delay;
            held      <= '0;
            l_elapsed <= '0;
            l_dur     <= '0;
            l_period  <= '0;
            l_span    <= '0;
            t_wait    <= start_delay;
            t_elapsed <= '0;
            t_dur     <= '0;
            t_period  <= '0;
            t_span    <= '0;
            drive     <= '0;
          end
        endcase
      end

      if (state == lbps_pkg::ST_LWAIT && rs.done && l_run) begin
        if (l_live) begin
          drive[3:1] <= l_lit ? {l_colour[3], l_colour[2], l_colour[0]} : 3'b000;
        end else begin
          // expired or never loaded: lamp dark, pattern released
          l_dur      <= '0;
          drive[3:1] <= 3'b000;
          held       <= '0;
        end
      end

      if (state == lbps_pkg::ST_TWAIT && rs.done && t_run) begin
        if (t_live) begin
          drive[0] <= (rs.rem < t_span);
        end else begin
          t_dur    <= '0;
          drive[0] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == lbps_pkg::ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lbps_pkg::ST_OUT && out_free) begin
      m_tdata <= {7'b0, held, drive[0], drive[1], drive[2], drive[3]};
    end
  end

  lbps_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rq),
    .rsp (rs)
  );

  `ASSERT_IMPLIES(a_done_in_wait, rs.done,
    state == lbps_pkg::ST_LWAIT || state == lbps_pkg::ST_TWAIT, "divider done out of sequence")
  `ASSERT_IMPLIES(a_idle_unit_free, state == lbps_pkg::ST_IDLE || state == lbps_pkg::ST_OUT,
    !rs.busy, "divider busy outside a tick")
  `ASSERT_NEXT(a_out_loads, state == lbps_pkg::ST_OUT && out_free, m_tvalid,
    "result not presented after output step")

endmodule

[tb/led_buzzer_pattern_sequencer_test.sv]
`timescale 1ns / 1ps

module led_buzzer_pattern_sequencer_test;

  localparam int QuietLimit = 3000;
  localparam int HoldLen    = 400;
  localparam int DirRows    = 25;

  // laid out as m_tdata[8:0]
  typedef struct packed {
    logic [4:0] pat;
    logic       buzz;
    logic       blue;
    logic       green;
    logic       red;
  } drive_word_t;

  typedef struct {
    lbps_pkg::req_t rq;
    logic [4:0]     pt;
    bit             typed;
    drive_word_t    word;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [4:0] pattern
  logic [1:0]  s_tuser = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [0] red [1] green [2] blue [3] buzzer [8:4] light_pattern
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  led_buzzer_pattern_sequencer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predicted block state
  logic [7:0]  model_delay;
  logic [4:0]  lamp_pattern;
  logic [7:0]  lamp_wait;
  logic [15:0] lamp_elapsed, lamp_len, lamp_period, lamp_span;
  logic [3:0]  lamp_colour;
  logic [7:0]  tone_wait;
  logic [15:0] tone_elapsed, tone_len, tone_period, tone_span;
  logic [3:0]  drive_bits;   // 3 red, 2 green, 1 blue, 0 buzzer

  drive_word_t pending_drives[$];
  dir_row_t    dir_rows [DirRows];
  int          mismatches = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet = 0;

  function automatic drive_word_t sequence_next(input lbps_pkg::req_t rq, input logic [4:0] pt);
    drive_word_t w;
    logic [15:0] rem;
    logic        take;
    case (rq)
      lbps_pkg::REQ_TICK: begin
        if (lamp_wait == 0) begin
          lamp_elapsed = lamp_elapsed + 16'd1;
          if (lamp_len != 0) begin
            if (lamp_len == lbps_pkg::PatEndless || lamp_elapsed < lamp_len) begin
              rem = (lamp_period == 0) ? lamp_elapsed : lamp_elapsed % lamp_period;
              if (lamp_period == lbps_pkg::PatEndless || rem < lamp_span)
                drive_bits[3:1] = {lamp_colour[3], lamp_colour[2], lamp_colour[0]};
              else
                drive_bits[3:1] = 3'b000;
            end else begin
              lamp_len = '0;
            end
          end
          if (lamp_len == 0) begin
            drive_bits[3:1] = 3'b000;
            lamp_pattern = '0;
          end
        end else begin
          lamp_wait = lamp_wait - 8'd1;
        end
        if (tone_wait == 0) begin
          tone_elapsed = tone_elapsed + 16'd1;
          if (tone_len != 0) begin
            if (tone_elapsed < tone_len) begin
              rem = (tone_period == 0) ? tone_elapsed : tone_elapsed % tone_period;
              drive_bits[0] = (rem < tone_span);
            end else begin
              tone_len = '0;
            end
          end
          if (tone_len == 0) drive_bits[0] = 1'b0;
        end else begin
          tone_wait = tone_wait - 8'd1;
        end
      end
      lbps_pkg::REQ_LIGHT: begin
        // high patterns yield to any other; low ones only to a lower number
        if (lamp_pattern >= 7) take = (lamp_pattern != pt);
        else take = (lamp_pattern == 0) || (pt < lamp_pattern);
        if (take) begin
          lamp_wait = model_delay;
          lamp_pattern = pt;
          lamp_elapsed = '0;
          case (pt)
            5'd1, 5'd2, 5'd3: {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd20, 16'd40, 16'd20, 4'h1};
            5'd4:  {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd80, 16'd40, 16'd20, 4'h8};
            5'd5:  {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd20, 16'd40, 16'd20, 4'h4};
            5'd6:  {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd255, 16'd100, 16'd50, 4'h4};
            5'd7:  {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd255, 16'd255, 16'd255, 4'h4};
            5'd8:  {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd255, 16'd255, 16'd255, 4'h8};
            5'd9:  {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd255, 16'd120, 16'd60, 4'h1};
            5'd10: {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd255, 16'd300, 16'd200, 4'hD};
            5'd11: {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd255, 16'd255, 16'd255, 4'h5};
            5'd12: {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd36, 16'd12, 16'd6, 4'h4};
            5'd13: {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd60, 16'd20, 16'd10, 4'h1};
            5'd14: {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd255, 16'd120, 16'd60, 4'h8};
            5'd15: {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd255, 16'd80, 16'd40, 4'hD};
            5'd16: {lamp_len, lamp_period, lamp_span, lamp_colour} =
                {16'd255, 16'd60, 16'd30, 4'h8};
            default: ;  // no row: timing kept
          endcase
        end
      end
      lbps_pkg::REQ_BUZZ: begin
        tone_wait = model_delay;
        tone_elapsed = '0;
        case (pt)
          5'd1: {tone_len, tone_period, tone_span} = {16'd20, 16'd40, 16'd20};
          5'd2: {tone_len, tone_period, tone_span} = {16'd80, 16'd40, 16'd20};
          5'd3: {tone_len, tone_period, tone_span} = {16'd160, 16'd80, 16'd40};
          5'd4: {tone_len, tone_period, tone_span} = {16'd500, 16'hFFFF, 16'hFFFF};
          5'd5: {tone_len, tone_period, tone_span} = {16'd30, 16'd10, 16'd5};
          5'd6: {tone_len, tone_period, tone_span} = {16'd60, 16'd20, 16'd10};
          default: ;
        endcase
      end
      default: begin
        // force off keeps the colour
        lamp_wait = model_delay;
        lamp_pattern = '0;
        {lamp_elapsed, lamp_len, lamp_period, lamp_span} = '0;
        tone_wait = model_delay;
        {tone_elapsed, tone_len, tone_period, tone_span} = '0;
        drive_bits = 4'b0000;
      end
    endcase
    w.pat   = lamp_pattern;
    w.red   = drive_bits[3];
    w.green = drive_bits[2];
    w.blue  = drive_bits[1];
    w.buzz  = drive_bits[0];
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // called just after a falling edge; returns just after a falling edge, once the request has been accepted
  task automatic send_request(input lbps_pkg::req_t rq, input logic [4:0] pt,
                              input bit typed = 1'b0, input drive_word_t typed_word = '0);
    drive_word_t want;
    want = sequence_next(rq, pt);
    if (typed) want = typed_word;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, pt};
    s_tuser  <= rq;
    do @(posedge clk); while (!s_tready);
    pending_drives.push_back(want);
    @(negedge clk);
  endtask

  task automatic write_start_delay(input logic [7:0] value);
    s_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    model_delay = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HoldLen;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    drive_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_drives.size() == 0) begin
        report_mismatch("unexpected result", int'(m_tdata), 0);
      end else begin
        want = pending_drives.pop_front();
        if (m_tdata[0] !== want.red)
          report_mismatch("red_on", int'(m_tdata[0]), int'(want.red));
        if (m_tdata[1] !== want.green)
          report_mismatch("green_on", int'(m_tdata[1]), int'(want.green));
        if (m_tdata[2] !== want.blue)
          report_mismatch("blue_on", int'(m_tdata[2]), int'(want.blue));
        if (m_tdata[3] !== want.buzz)
          report_mismatch("buzzer_on", int'(m_tdata[3]), int'(want.buzz));
        if (m_tdata[8:4] !== want.pat)
          report_mismatch("light_pattern", int'(m_tdata[8:4]), int'(want.pat));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int   phase;
    int   sent;
    int   quota;
    int   run;
    int   pick;
    logic [7:0] delay_set;

    model_delay  = lbps_pkg::StartDelayReset;
    lamp_pattern = '0;
    {lamp_wait, lamp_elapsed, lamp_len, lamp_period, lamp_span, lamp_colour} = '0;
    {tone_wait, tone_elapsed, tone_len, tone_period, tone_span} = '0;
    drive_bits   = 4'b0000;

    // directed table, run with no start delay
    dir_rows[0]  = '{lbps_pkg::REQ_TICK,  5'd0,  1'b1, 9'h000};
    dir_rows[1]  = '{lbps_pkg::REQ_LIGHT, 5'd7,  1'b1, 9'h070};
    dir_rows[2]  = '{lbps_pkg::REQ_TICK,  5'd0,  1'b1, 9'h072};  // steady green
    dir_rows[3]  = '{lbps_pkg::REQ_LIGHT, 5'd7,  1'b0, 9'h000};  // same pattern, ignored
    dir_rows[4]  = '{lbps_pkg::REQ_LIGHT, 5'd3,  1'b0, 9'h000};
    dir_rows[5]  = '{lbps_pkg::REQ_LIGHT, 5'd5,  1'b0, 9'h000};  // higher than held low one
    dir_rows[6]  = '{lbps_pkg::REQ_LIGHT, 5'd1,  1'b0, 9'h000};
    dir_rows[7]  = '{lbps_pkg::REQ_TICK,  5'd0,  1'b0, 9'h000};
    dir_rows[8]  = '{lbps_pkg::REQ_BUZZ,  5'd4,  1'b0, 9'h000};
    dir_rows[9]  = '{lbps_pkg::REQ_TICK,  5'd0,  1'b0, 9'h000};
    dir_rows[10] = '{lbps_pkg::REQ_BUZZ,  5'd0,  1'b0, 9'h000};  // no row, timing kept
    dir_rows[11] = '{lbps_pkg::REQ_LIGHT, 5'd0,  1'b0, 9'h000};
    dir_rows[12] = '{lbps_pkg::REQ_LIGHT, 5'd31, 1'b0, 9'h000};
    dir_rows[13] = '{lbps_pkg::REQ_LIGHT, 5'd17, 1'b0, 9'h000};
    dir_rows[14] = '{lbps_pkg::REQ_LIGHT, 5'd10, 1'b0, 9'h000};
    dir_rows[15] = '{lbps_pkg::REQ_TICK,  5'd0,  1'b0, 9'h000};
    dir_rows[16] = '{lbps_pkg::REQ_BUZZ,  5'd7,  1'b0, 9'h000};
    dir_rows[17] = '{lbps_pkg::REQ_BUZZ,  5'd31, 1'b0, 9'h000};
    dir_rows[18] = '{lbps_pkg::REQ_LIGHT, 5'd16, 1'b0, 9'h000};
    dir_rows[19] = '{lbps_pkg::REQ_TICK,  5'd0,  1'b0, 9'h000};
    dir_rows[20] = '{lbps_pkg::REQ_FORCE, 5'd31, 1'b1, 9'h000};
    dir_rows[21] = '{lbps_pkg::REQ_BUZZ,  5'd5,  1'b0, 9'h000};
    dir_rows[22] = '{lbps_pkg::REQ_TICK,  5'd0,  1'b0, 9'h000};
    dir_rows[23] = '{lbps_pkg::REQ_LIGHT, 5'd12, 1'b0, 9'h000};
    dir_rows[24] = '{lbps_pkg::REQ_TICK,  5'd0,  1'b0, 9'h000};

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_start_delay(8'd0);
    for (int i = 0; i < DirRows; i++)
      send_request(dir_rows[i].rq, dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].word);

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  delay_set = 8'd1; quota = 180; end
        1: begin idle_pct = 78; stall_pct = 0;  delay_set = 8'd4; quota = 180; end
        2: begin idle_pct = 0;  stall_pct = 78; delay_set = 8'd0; quota = 180; end
        3: begin
          idle_pct = 27; stall_pct = 27;
          delay_set = 8'($urandom_range(0, 12)); quota = 150;
        end
        default: begin idle_pct = 0; stall_pct = 0; delay_set = 8'd255; quota = 40; end
      endcase
      write_start_delay(delay_set);
      // long receiver hold while the sender keeps offering
      if (phase == 0) hold_asks = hold_asks + 1;
      sent = 0;
      while (sent < quota) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          send_request(lbps_pkg::req_t'(2'($urandom_range(0, 3))), 5'($urandom_range(0, 31)));
          sent++;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 55)
            send_request(lbps_pkg::REQ_LIGHT, ($urandom_range(0, 6) == 0) ?
                         5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16)));
          else if (pick < 93)
            send_request(lbps_pkg::REQ_BUZZ, ($urandom_range(0, 6) == 0) ?
                         5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6)));
          else
            send_request(lbps_pkg::REQ_FORCE, 5'($urandom_range(0, 31)));
          run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 30);
          for (int k = 0; k < run; k++)
            send_request(lbps_pkg::REQ_TICK, 5'($urandom_range(0, 31)));
          sent += 1 + run;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/lbps_pkg.sv
rtl/lbps_rem.sv
rtl/led_buzzer_pattern_sequencer.sv
tb/led_buzzer_pattern_sequencer_test.sv
